FILE: design/htd_pkg.sv
// Shared constants, record types and helper functions of the Huffman tree-walk decoder.
// Used by the channel interfaces, the output queue and the top level; depends on nothing.
`default_nettype none

package htd_pkg;

	localparam int TREE_NODES = 512;
	localparam int CHANNELS   = 3;

	localparam int CH_W     = 2;
	localparam int IDX_W    = 9;
	localparam int SYM_W    = 8;
	localparam int QUAL_W   = 8;
	localparam int COUNT_W  = 24;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MEM_DEPTH = CHANNELS * TREE_NODES;
	localparam int ADDR_W   = $clog2(MEM_DEPTH);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic REG_QUALITY     = 1'b0;
	localparam logic REG_PIXEL_COUNT = 1'b1;

	localparam logic [QUAL_W-1:0]  QUALITY_RESET     = QUAL_W'(1);
	localparam logic [COUNT_W-1:0] PIXEL_COUNT_RESET = COUNT_W'(1);

	typedef struct packed {
		logic [IDX_W-1:0] right_index;
		logic             right_present;
		logic [IDX_W-1:0] left_index;
		logic             left_present;
		logic [SYM_W-1:0] symbol;
	} node_rec_t;

	localparam int REC_W = $bits(node_rec_t);

	typedef struct packed {
		logic [CH_W-1:0]  out_channel;
		logic [SYM_W-1:0] pixel;
		logic             last_pixel;
		logic             bad_code;
	} result_t;

	// Symbol times quality times ten, kept to the low byte; the times ten is a shift and add.
	function automatic logic [SYM_W-1:0] scale_pixel(input logic [SYM_W-1:0] sym,
		input logic [QUAL_W-1:0] qual);
		logic [SYM_W+QUAL_W-1:0] prod;
		logic [SYM_W-1:0]        low;
		prod = sym * qual;
		low  = prod[SYM_W-1:0];
		return SYM_W'({low, 3'b000}) + SYM_W'({low, 1'b0});
	endfunction

endpackage

`default_nettype wire

FILE: design/htd_if.sv
// Valid/ready channel interfaces for the decoder's input items and result items.
// Field widths come from htd_pkg.
`default_nettype none

interface htd_in_if;
	import htd_pkg::*;

	logic             valid;
	logic             ready;
	logic             operation;
	logic [CH_W-1:0]  channel;
	logic [IDX_W-1:0] node_index;
	logic [SYM_W-1:0] node_symbol;
	logic             left_present;
	logic [IDX_W-1:0] left_index;
	logic             right_present;
	logic [IDX_W-1:0] right_index;
	logic             code_bit;

	modport source (
		output valid, operation, channel, node_index, node_symbol,
		output left_present, left_index, right_present, right_index, code_bit,
		input  ready
	);

	modport sink (
		input  valid, operation, channel, node_index, node_symbol,
		input  left_present, left_index, right_present, right_index, code_bit,
		output ready
	);
endinterface

interface htd_out_if;
	import htd_pkg::*;

	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  out_channel;
	logic [SYM_W-1:0] pixel;
	logic             last_pixel;
	logic             bad_code;

	modport source (
		output valid, out_channel, pixel, last_pixel, bad_code,
		input  ready
	);

	modport sink (
		input  valid, out_channel, pixel, last_pixel, bad_code,
		output ready
	);
endinterface

`default_nettype wire

FILE: design/htd_node_ram.sv
// Simple dual-port RAM holding the node records of all channel trees.
// One write port and one read port with registered read data; no dependencies.
`default_nettype none

module htd_node_ram #(
	parameter int DEPTH = 1536,
	parameter int WIDTH = 28
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

FILE: design/htd_out_fifo.sv
// Small result queue that decouples the decode pipeline from the result receiver.
// Uses result_t and the queue depth from htd_pkg, and drives the result channel.
`default_nettype none

module htd_out_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire htd_pkg::result_t     push_data,
	output logic [htd_pkg::FIFO_AW:0] level,
	htd_out_if.source                 results
);
	import htd_pkg::*;

	result_t            entries_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   count_q;
	logic               pop;
	result_t            head;

	assign pop   = results.valid && results.ready;
	assign level = count_q;
	assign head  = entries_q[rd_q];

	assign results.valid       = (count_q != '0);
	assign results.out_channel = head.out_channel;
	assign results.pixel       = head.pixel;
	assign results.last_pixel  = head.last_pixel;
	assign results.bad_code    = head.bad_code;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (FIFO_AW + 1)'(1);
				2'b01:   count_q <= count_q - (FIFO_AW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

`default_nettype wire

FILE: design/huffman_tree_walk_decoder.sv
// Top level of the Huffman tree-walk decoder: APB registers, node RAM, decode stage
// and result queue. Depends on htd_pkg, htd_if, htd_node_ram and htd_out_fifo.
//
// Input items arrive on the items channel. A load item writes one node record of a
// channel's tree into the node RAM; a decode item moves that channel's walk by one code
// bit. Each channel keeps its current node and a copy of that node's record in flip-flops,
// so a bit needs one RAM read, of the child record, issued at the edge that takes it.
// The next edge classifies the child and updates the walk; a leaf or a missing child
// places a result item in a four-entry queue that feeds the results channel.
// One item is taken every cycle while the result queue has room; a result is offered on
// the results channel from the edge after the one that takes its decode item. Bits for
// one channel may follow each other directly, as the record chosen for the walk is
// forwarded from the decode stage. Quality and pixel count are written over the APB
// port at byte addresses 0 and 4; the user must write them only while the block is
// idle; the block itself does not enforce this. Reset returns every walk to its root,
// clears the symbol counters and restores quality and pixel count to one; node records
// must be loaded again. When the receiver stalls the queue fills, and items.ready falls
// once the queue could no longer hold the result of a further item; nothing is lost.
`default_nettype none

module huffman_tree_walk_decoder (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [htd_pkg::APB_AW-1:0] paddr,
	input  wire logic [htd_pkg::APB_DW-1:0] pwdata,
	output logic      [htd_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	htd_in_if.sink                          items,
	htd_out_if.source                       results
);
	import htd_pkg::*;

	// Configuration registers.
	logic [QUAL_W-1:0]  quality_q;
	logic [COUNT_W-1:0] pixel_count_q;
	logic               cfg_we;

	// Per-channel walk state.
	logic [IDX_W-1:0]   cur_node_q [CHANNELS];
	node_rec_t          cur_rec_q  [CHANNELS];
	node_rec_t          root_rec_q [CHANNELS];
	logic [COUNT_W-1:0] done_q     [CHANNELS];

	// Input side.
	logic                accept;
	logic                ch_ok_in;
	logic [CH_IDX_W-1:0] chi_in;
	logic                fwd_hit;
	node_rec_t           eff_rec;
	logic                side_present;
	logic [IDX_W-1:0]    side_child;
	logic                child_ok;
	node_rec_t           load_rec;
	logic                mem_we;
	logic                mem_re;
	logic [ADDR_W-1:0]   waddr;
	logic [ADDR_W-1:0]   raddr;
	node_rec_t           crec;

	// Decode stage.
	logic                valid_s1;
	logic                op_s1;
	logic                ch_ok_s1;
	logic [CH_W-1:0]     ch_s1;
	logic [IDX_W-1:0]    slot_s1;
	logic                slot_ok_s1;
	node_rec_t           lrec_s1;
	logic                present_s1;
	logic [IDX_W-1:0]    child_s1;
	logic                child_ok_s1;

	logic [CH_IDX_W-1:0] chi_s1;
	logic                load_s1;
	logic                active_s1;
	logic                bad_s1;
	logic                leaf_s1;
	logic [COUNT_W-1:0]  done_next;
	logic                rec_we;
	node_rec_t           rec_wdata;
	logic                root_we;
	logic                node_we;
	logic [IDX_W-1:0]    node_wdata;
	logic                done_we;
	logic                res_push;
	result_t             res_data;
	logic [FIFO_AW:0]    fifo_level;

	function automatic logic [ADDR_W-1:0] node_addr(input logic [CH_IDX_W-1:0] chi,
		input logic [IDX_W-1:0] slot);
		return ADDR_W'(chi) * ADDR_W'(TREE_NODES) + ADDR_W'(slot);
	endfunction

	// APB register port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_QUALITY:     prdata = APB_DW'(quality_q);
			REG_PIXEL_COUNT: prdata = APB_DW'(pixel_count_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quality_q     <= QUALITY_RESET;
			pixel_count_q <= PIXEL_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_QUALITY:     quality_q     <= pwdata[QUAL_W-1:0];
				REG_PIXEL_COUNT: pixel_count_q <= pwdata[COUNT_W-1:0];
				default:         quality_q     <= quality_q;
			endcase
		end
	end

	// Input side: pick the walk record, select the child and start its RAM read.
	assign items.ready = 32'(fifo_level) + 32'(valid_s1) < 32'(FIFO_DEPTH);
	assign accept      = items.valid && items.ready;
	assign ch_ok_in    = 32'(items.channel) < 32'(CHANNELS);
	assign chi_in      = ch_ok_in ? items.channel[CH_IDX_W-1:0] : '0;
	assign fwd_hit     = rec_we && (chi_s1 == chi_in);
	assign eff_rec     = fwd_hit ? rec_wdata : cur_rec_q[chi_in];

	always_comb begin
		if (items.code_bit) begin
			side_present = eff_rec.right_present;
			side_child   = eff_rec.right_index;
		end else begin
			side_present = eff_rec.left_present;
			side_child   = eff_rec.left_index;
		end
	end

	assign child_ok = 32'(side_child) < 32'(TREE_NODES);

	assign load_rec.symbol        = items.node_symbol;
	assign load_rec.left_present  = items.left_present;
	assign load_rec.left_index    = items.left_index;
	assign load_rec.right_present = items.right_present;
	assign load_rec.right_index   = items.right_index;

	assign mem_we = accept && (items.operation == OP_LOAD) && ch_ok_in &&
		(32'(items.node_index) < 32'(TREE_NODES));
	assign mem_re = accept && (items.operation == OP_DECODE) && ch_ok_in;
	assign waddr  = node_addr(chi_in, items.node_index);
	assign raddr  = node_addr(chi_in, child_ok ? side_child : '0);

	htd_node_ram #(
		.DEPTH (MEM_DEPTH),
		.WIDTH (REC_W)
	) u_node_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (load_rec),
		.re    (mem_re),
		.raddr (raddr),
		.rdata (crec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= items.operation;
			ch_ok_s1    <= ch_ok_in;
			ch_s1       <= items.channel;
			slot_s1     <= items.node_index;
			slot_ok_s1  <= 32'(items.node_index) < 32'(TREE_NODES);
			lrec_s1     <= load_rec;
			present_s1  <= side_present;
			child_s1    <= side_child;
			child_ok_s1 <= child_ok;
		end
	end

	// Decode stage: classify the child and update the channel's walk.
	assign chi_s1    = ch_s1[CH_IDX_W-1:0];
	assign load_s1   = valid_s1 && ch_ok_s1 && (op_s1 == OP_LOAD) && slot_ok_s1;
	assign active_s1 = valid_s1 && ch_ok_s1 && (op_s1 == OP_DECODE) &&
		(done_q[chi_s1] < pixel_count_q);
	assign bad_s1    = !present_s1 || !child_ok_s1;
	assign leaf_s1   = !crec.left_present && !crec.right_present;
	assign done_next = done_q[chi_s1] + COUNT_W'(1);

	always_comb begin
		rec_we     = 1'b0;
		rec_wdata  = lrec_s1;
		root_we    = 1'b0;
		node_we    = 1'b0;
		node_wdata = '0;
		done_we    = 1'b0;
		if (load_s1) begin
			rec_we  = (slot_s1 == cur_node_q[chi_s1]);
			root_we = (slot_s1 == '0);
		end else if (active_s1) begin
			rec_we  = 1'b1;
			node_we = 1'b1;
			if (bad_s1) begin
				rec_wdata = root_rec_q[chi_s1];
			end else if (leaf_s1) begin
				rec_wdata = root_rec_q[chi_s1];
				done_we   = 1'b1;
			end else begin
				rec_wdata  = crec;
				node_wdata = child_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cur_node_q[i] <= '0;
				cur_rec_q[i]  <= '0;
				root_rec_q[i] <= '0;
				done_q[i]     <= '0;
			end
		end else begin
			if (rec_we) begin
				cur_rec_q[chi_s1] <= rec_wdata;
			end
			if (root_we) begin
				root_rec_q[chi_s1] <= lrec_s1;
			end
			if (node_we) begin
				cur_node_q[chi_s1] <= node_wdata;
			end
			if (done_we) begin
				done_q[chi_s1] <= done_next;
			end
		end
	end

	assign res_push             = active_s1 && (bad_s1 || leaf_s1);
	assign res_data.out_channel = ch_s1;
	assign res_data.pixel       = bad_s1 ? '0 : scale_pixel(crec.symbol, quality_q);
	assign res_data.last_pixel  = !bad_s1 && (done_next == pixel_count_q);
	assign res_data.bad_code    = bad_s1;

	htd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.level     (fifo_level),
		.results   (results)
	);

	// The credit check on items.ready must leave room for every result.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (32'(fifo_level) < 32'(FIFO_DEPTH)))
		else $error("result queue overflow");

	// A bad code reports neither a pixel value nor the end of a channel.
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.bad_code) |-> (results.pixel == '0 && !results.last_pixel))
		else $error("bad code result carries pixel data");

	// A decode that ends at a leaf or a missing child sends the walk back to the root.
	a_root_return: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (node_we && node_wdata == '0))
		else $error("walk not returned to root after result");
endmodule

`default_nettype wire

FILE: tb/huffman_tree_walk_decoder_tb.sv
// Self-checking testbench for the Huffman tree-walk decoder. Random trees and code bits are fed
// to the block under several register settings and handshake patterns. Each result is compared
// with a scoreboard that tracks the walk. Depends on htd_pkg, htd_if and the decoder RTL.
`default_nettype none

module huffman_tree_walk_decoder_tb;
	import htd_pkg::*;

	localparam int SCALE_STEP  = 10;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 12;
	localparam logic [CH_W-1:0]   NO_CHANNEL       = CH_W'(CHANNELS);
	localparam logic [APB_AW-1:0] ADDR_QUALITY     = {REG_QUALITY, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_PIXEL_COUNT = {REG_PIXEL_COUNT, 2'b00};

	typedef struct {
		logic             operation;
		logic [CH_W-1:0]  channel;
		logic [IDX_W-1:0] node_index;
		logic [SYM_W-1:0] node_symbol;
		logic             left_present;
		logic [IDX_W-1:0] left_index;
		logic             right_present;
		logic [IDX_W-1:0] right_index;
		logic             code_bit;
	} walk_item_t;

	class decode_scoreboard;
		node_rec_t          tree_mem [CHANNELS][TREE_NODES];
		logic [IDX_W-1:0]   walk_node [CHANNELS];
		logic [COUNT_W-1:0] symbols_seen [CHANNELS];
		logic [QUAL_W-1:0]  quality;
		logic [COUNT_W-1:0] pixel_count;
		result_t            pixel_q [$];
		int                 errors;
		int                 items_applied;
		int                 pixels_ok;
		int                 bad_ok;
		int                 last_ok;

		function new();
			for (int c = 0; c < CHANNELS; c++) begin
				walk_node[c]    = '0;
				symbols_seen[c] = '0;
			end
			quality     = QUALITY_RESET;
			pixel_count = PIXEL_COUNT_RESET;
		endfunction

		function logic [COUNT_W-1:0] most_decoded();
			logic [COUNT_W-1:0] most;
			most = '0;
			for (int c = 0; c < CHANNELS; c++)
				if (symbols_seen[c] > most)
					most = symbols_seen[c];
			return most;
		endfunction

		function void note_item(walk_item_t it);
			node_rec_t        cur;
			node_rec_t        nxt;
			logic             present;
			logic [IDX_W-1:0] child;
			result_t          r;
			int unsigned      prod;
			int               ch;
			if (it.channel >= CHANNELS)
				return;
			ch = it.channel;
			items_applied++;
			if (it.operation == OP_LOAD) begin
				if (it.node_index < TREE_NODES)
					tree_mem[ch][it.node_index] = '{right_index: it.right_index,
						right_present: it.right_present, left_index: it.left_index,
						left_present: it.left_present, symbol: it.node_symbol};
				return;
			end
			if (symbols_seen[ch] >= pixel_count)
				return;
			cur     = tree_mem[ch][walk_node[ch]];
			present = it.code_bit ? cur.right_present : cur.left_present;
			child   = it.code_bit ? cur.right_index : cur.left_index;
			r.out_channel = it.channel;
			if (!present || child >= TREE_NODES) begin
				walk_node[ch] = '0;
				r.pixel       = '0;
				r.last_pixel  = 1'b0;
				r.bad_code    = 1'b1;
				pixel_q = {pixel_q, r};
				return;
			end
			nxt = tree_mem[ch][child];
			if (nxt.left_present || nxt.right_present) begin
				walk_node[ch] = child;
				return;
			end
			walk_node[ch]    = '0;
			symbols_seen[ch] = symbols_seen[ch] + 1'b1;
			prod = int'(nxt.symbol) * int'(quality) * SCALE_STEP;
			r.pixel      = prod[SYM_W-1:0];
			r.last_pixel = (symbols_seen[ch] == pixel_count);
			r.bad_code   = 1'b0;
			pixel_q = {pixel_q, r};
		endfunction

		function void check_pixel(result_t got);
			result_t want;
			if (pixel_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: got ch %0d pixel %0d last %0b bad %0b",
					$time, got.out_channel, got.pixel, got.last_pixel, got.bad_code);
				return;
			end
			want = pixel_q.pop_front();
			if (got.out_channel !== want.out_channel || got.pixel !== want.pixel ||
				got.last_pixel !== want.last_pixel || got.bad_code !== want.bad_code) begin
				errors++;
				$display("%0t: expected ch %0d pixel %0d last %0b bad %0b, got ch %0d pixel %0d last %0b bad %0b",
					$time, want.out_channel, want.pixel, want.last_pixel, want.bad_code,
					got.out_channel, got.pixel, got.last_pixel, got.bad_code);
			end else begin
				if (got.bad_code)
					bad_ok++;
				else
					pixels_ok++;
				if (got.last_pixel)
					last_ok++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	htd_in_if  items ();
	htd_out_if results ();

	huffman_tree_walk_decoder u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (items),
		.results (results)
	);

	decode_scoreboard sb = new();

	walk_item_t       pending_q [$];
	bit               written [CHANNELS][TREE_NODES];
	logic [IDX_W-1:0] written_list [CHANNELS][TREE_NODES];
	int               written_cnt [CHANNELS];
	int               stall_pct;
	int               hold_left;
	int               quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				results.ready <= 1'b0;
				hold_left--;
			end else begin
				results.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		walk_item_t seen;
		result_t    got;
		quiet_cycles++;
		if (items.valid && items.ready) begin
			seen = '{items.operation, items.channel, items.node_index, items.node_symbol,
				items.left_present, items.left_index, items.right_present, items.right_index,
				items.code_bit};
			sb.note_item(seen);
			quiet_cycles = 0;
		end
		if (results.valid && results.ready) begin
			got = '{out_channel: results.out_channel, pixel: results.pixel,
				last_pixel: results.last_pixel, bad_code: results.bad_code};
			sb.check_pixel(got);
			quiet_cycles = 0;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic walk_item_t random_item();
		walk_item_t it;
		it.operation     = 1'($urandom);
		it.channel       = CH_W'($urandom);
		it.node_index    = IDX_W'($urandom);
		it.node_symbol   = SYM_W'($urandom);
		it.left_present  = 1'($urandom);
		it.left_index    = IDX_W'($urandom);
		it.right_present = 1'($urandom);
		it.right_index   = IDX_W'($urandom);
		it.code_bit      = 1'($urandom);
		return it;
	endfunction

	function automatic void push_load(int ch, logic [IDX_W-1:0] slot, logic [SYM_W-1:0] sym,
		logic lp, logic [IDX_W-1:0] li, logic rp, logic [IDX_W-1:0] ri);
		walk_item_t it;
		it = random_item();
		it.operation     = OP_LOAD;
		it.channel       = CH_W'(ch);
		it.node_index    = slot;
		it.node_symbol   = sym;
		it.left_present  = lp;
		it.left_index    = li;
		it.right_present = rp;
		it.right_index   = ri;
		pending_q = {pending_q, it};
		if (ch < CHANNELS && !written[ch][slot]) begin
			written[ch][slot] = 1'b1;
			written_list[ch][written_cnt[ch]] = slot;
			written_cnt[ch]++;
		end
	endfunction

	function automatic void push_decode(int ch, logic cb);
		walk_item_t it;
		it = random_item();
		it.operation = OP_DECODE;
		it.channel   = CH_W'(ch);
		it.code_bit  = cb;
		pending_q = {pending_q, it};
	endfunction

	function automatic logic [IDX_W-1:0] pick_written(int ch);
		return written_list[ch][$urandom_range(written_cnt[ch] - 1)];
	endfunction

	// Builds a random tree top down, then loads it bottom up so that no
	// record ever points at a slot that has not been written.
	function automatic void queue_tree(int ch);
		logic [IDX_W-1:0] slot_of [32];
		int               depth_of [32];
		bit               leaf_of [32];
		bit               lp [32];
		bit               rp [32];
		logic [IDX_W-1:0] li [32];
		logic [IDX_W-1:0] ri [32];
		bit               used [TREE_NODES];
		int               n;
		bit               has;
		logic [IDX_W-1:0] s;
		logic [IDX_W-1:0] pick;
		for (int k = 0; k < TREE_NODES; k++)
			used[k] = 1'b0;
		used[0]     = 1'b1;
		slot_of[0]  = '0;
		depth_of[0] = 0;
		leaf_of[0]  = 1'b0;
		n = 1;
		for (int i = 0; i < n; i++) begin
			for (int side = 0; side < 2; side++) begin
				has  = !leaf_of[i] && ($urandom_range(99) >= 8);
				pick = IDX_W'($urandom);
				if (has) begin
					do s = IDX_W'($urandom_range(TREE_NODES - 1, 1)); while (used[s]);
					used[s]     = 1'b1;
					slot_of[n]  = s;
					depth_of[n] = depth_of[i] + 1;
					leaf_of[n]  = (depth_of[n] >= 4) || ($urandom_range(99) < 35);
					pick = s;
					n++;
				end
				if (side == 0) begin
					lp[i] = has;
					li[i] = pick;
				end else begin
					rp[i] = has;
					ri[i] = pick;
				end
			end
		end
		for (int i = n - 1; i >= 0; i--)
			push_load(ch, slot_of[i], SYM_W'($urandom), lp[i], li[i], rp[i], ri[i]);
	endfunction

	function automatic void queue_stray_load();
		int               ch;
		logic             lp;
		logic             rp;
		logic [IDX_W-1:0] li;
		logic [IDX_W-1:0] ri;
		ch = $urandom_range(CHANNELS - 1);
		lp = 1'($urandom) && (written_cnt[ch] > 0);
		rp = 1'($urandom) && (written_cnt[ch] > 0);
		li = lp ? pick_written(ch) : IDX_W'($urandom);
		ri = rp ? pick_written(ch) : IDX_W'($urandom);
		push_load(ch, IDX_W'($urandom), SYM_W'($urandom), lp, li, rp, ri);
	endfunction

	function automatic void queue_traffic(int count);
		walk_item_t  it;
		int unsigned r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 4) begin
				it = random_item();
				it.channel = NO_CHANNEL;
				pending_q = {pending_q, it};
			end else if (r < 10) begin
				queue_stray_load();
			end else begin
				push_decode($urandom_range(CHANNELS - 1), 1'($urandom));
			end
		end
	endfunction

	task automatic send_pending(int idle_pct);
		walk_item_t it;
		while (pending_q.size() > 0) begin
			it = pending_q.pop_front();
			while ($urandom_range(99) < idle_pct) begin
				items.valid <= 1'b0;
				@(posedge clk);
			end
			items.operation     <= it.operation;
			items.channel       <= it.channel;
			items.node_index    <= it.node_index;
			items.node_symbol   <= it.node_symbol;
			items.left_present  <= it.left_present;
			items.left_index    <= it.left_index;
			items.right_present <= it.right_present;
			items.right_index   <= it.right_index;
			items.code_bit      <= it.code_bit;
			items.valid         <= 1'b1;
			@(posedge clk);
			while (!items.ready)
				@(posedge clk);
		end
		items.valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (sb.pixel_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_register(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(logic [QUAL_W-1:0] q, logic [COUNT_W-1:0] pc);
		write_register(ADDR_QUALITY, APB_DW'(q));
		sb.quality = q;
		write_register(ADDR_PIXEL_COUNT, APB_DW'(pc));
		sb.pixel_count = pc;
	endtask

	initial begin
		int                 mode;
		int                 idle_pct;
		logic [QUAL_W-1:0]  q;
		logic [COUNT_W-1:0] most;
		logic [COUNT_W-1:0] pc;
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		items.valid         <= 1'b0;
		items.operation     <= OP_LOAD;
		items.channel       <= '0;
		items.node_index    <= '0;
		items.node_symbol   <= '0;
		items.left_present  <= 1'b0;
		items.left_index    <= '0;
		items.right_present <= 1'b0;
		items.right_index   <= '0;
		items.code_bit      <= 1'b0;
		stall_pct    = 0;
		hold_left    = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A short hand-made case: leaves at the extreme slots and symbols, a missing
		// child, a root without children, an unused channel and a finished channel.
		apply_settings(8'd255, 24'd3);
		push_load(0, 9'd511, 8'hFF, 1'b0, 9'h000, 1'b0, 9'h1FF);
		push_load(0, 9'd1, 8'h00, 1'b0, 9'h1FF, 1'b0, 9'h000);
		push_load(0, 9'd256, 8'h5A, 1'b1, 9'd1, 1'b0, 9'h1FF);
		push_load(0, 9'd0, 8'h00, 1'b1, 9'd511, 1'b1, 9'd256);
		push_load(1, 9'd170, 8'hAA, 1'b0, 9'h155, 1'b0, 9'h0AA);
		push_load(1, 9'd85, 8'h55, 1'b0, 9'h0AA, 1'b0, 9'h155);
		push_load(1, 9'd0, 8'h00, 1'b1, 9'd170, 1'b1, 9'd85);
		push_load(2, 9'd0, 8'h81, 1'b0, 9'h155, 1'b0, 9'h0AA);
		push_load(NO_CHANNEL, 9'd0, 8'hFF, 1'b1, 9'h1FF, 1'b1, 9'h1FF);
		push_decode(0, 1'b0);
		push_decode(0, 1'b1);
		push_decode(0, 1'b1);
		push_decode(0, 1'b1);
		push_decode(0, 1'b0);
		push_decode(1, 1'b0);
		push_decode(1, 1'b1);
		push_decode(2, 1'b0);
		push_decode(2, 1'b1);
		push_decode(0, 1'b0);
		push_decode(0, 1'b1);
		push_decode(1, 1'b0);
		push_decode(NO_CHANNEL, 1'b1);
		send_pending(0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			mode      = p % 4;
			idle_pct  = (mode == 1) ? 65 : (mode == 3) ? 17 : 0;
			stall_pct = (mode == 2) ? 65 : (mode == 3) ? 17 : 0;
			most = sb.most_decoded();
			case (p)
				0: q = 8'd0;
				1: q = 8'd1;
				3: q = 8'd255;
				default: q = QUAL_W'($urandom);
			endcase
			if (p == 2)
				pc = '0;
			else if (p == 5)
				pc = '1;
			else if (p == 3 || p == 7 || p == 10)
				pc = most + COUNT_W'($urandom_range(30, 4));
			else
				pc = COUNT_W'($urandom_range(24'hFFFFFF, most + 200));
			apply_settings(q, pc);
			for (int c = 0; c < CHANNELS; c++)
				queue_tree(c);
			queue_traffic((p == 2) ? 30 : 55);
			if (p == 4)
				hold_left = 300;
			send_pending(idle_pct);
			drain();
		end

		$display("Applied %0d items over %0d register settings: %0d pixels, %0d bad codes, %0d final pixels.",
			sb.items_applied, PHASES + 1, sb.pixels_ok, sb.bad_ok, sb.last_ok);
		if (sb.errors == 0 && sb.pixel_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
